### design/pcanon_pkg.sv
// Package for the path canonicalizer: operation codes, character constants,
// parse modes and the sequencer state type. No dependencies.
package pcanon_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_END  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// Result kinds.
	localparam logic KIND_END  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Characters with a meaning in a path.
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// Parse mode of the path being built.
	typedef enum logic [2:0] {
		MODE_START    = 3'd0,
		MODE_ABS_ROOT = 3'd1,
		MODE_ABS_DEEP = 3'd2,
		MODE_REL_INIT = 3'd3,
		MODE_REL_DEEP = 3'd4,
		MODE_REL_UP   = 3'd5
	} mode_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WALK  = 2'd1,
		ST_END   = 2'd2,
		ST_RDATA = 2'd3
	} state_t;

endpackage

### design/path_canonicalizer.sv
// Path canonicalizer top level: byte parser, component sequencer and the
// result store. Depends on pcanon_pkg.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   op, path_byte, read_index
// out      output     out_valid / out_ready result_kind, out_byte, out_length, overflowed
//
// A read passes through the store read register, then the output register.
// A ".." that cancels a component walks back through the store one byte per cycle to the
// previous separator; an end of path then goes on to load its result.
// in_ready is high only while the sequencer is idle; a result held by a stalled output
// does not block the next input until another result has to be loaded.
// Reset clears all control state; the store needs no clearing since only written bytes
// are ever read.
module path_canonicalizer
	import pcanon_pkg::*;
#(
	parameter int MAX_PATH_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  path_byte,
	input  logic [9:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  out_byte,
	output logic [10:0] out_length,
	output logic        overflowed
);

	localparam int AW = $clog2(MAX_PATH_BYTES);
	localparam int PW = AW + 1;
	localparam int CW = ((PW > 10) ? PW : 10) + 1;
	localparam logic [PW-1:0] MAXP = PW'(MAX_PATH_BYTES);
	localparam logic [PW-1:0] ONE = PW'(1);

	// Result store.
	logic [7:0] mem [MAX_PATH_BYTES];
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Control registers.
	state_t        state_q, state_d;
	mode_t         mode_q, mode_d;
	logic [PW-1:0] wp_q, wp_d, cl_q, cl_d, depth_q, depth_d, p_q, p_d;
	logic          ovf_q, ovf_d, pend_q, pend_d, fill_q, fill_d, rdok_q, rdok_d;
	logic [7:0]    b0_q, b0_d, b1_q, b1_d;
	logic          ov_q, ov_d, kind_q, kind_d, oflag_q, oflag_d;
	logic [7:0]    obyte_q, obyte_d;
	logic [10:0]   olen_q, olen_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_START;
			wp_q    <= '0;
			cl_q    <= '0;
			depth_q <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
			fill_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			wp_q    <= wp_d;
			cl_q    <= cl_d;
			depth_q <= depth_d;
			ovf_q   <= ovf_d;
			pend_q  <= pend_d;
			fill_q  <= fill_d;
			ov_q    <= ov_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		p_q     <= p_d;
		b0_q    <= b0_d;
		b1_q    <= b1_d;
		rdok_q  <= rdok_d;
		kind_q  <= kind_d;
		obyte_q <= obyte_d;
		olen_q  <= olen_d;
		oflag_q <= oflag_d;
	end

	// Component judgement from the current registers.
	logic          sep_cur, is_dot, is_up, accept, out_free, walk_more;
	logic [PW-1:0] cs_cur, pos_cur, wp_m1, p_fin, depth_m1;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !ov_q || out_ready;
	assign sep_cur  = (mode_q == MODE_ABS_DEEP) || (mode_q == MODE_REL_DEEP) ||
		(mode_q == MODE_REL_UP);
	assign cs_cur   = wp_q + (sep_cur ? ONE : '0);
	assign pos_cur  = cs_cur + cl_q;
	assign is_dot   = (cl_q == ONE) && (b0_q == CH_DOT);
	assign is_up    = (cl_q == PW'(2)) && (b0_q == CH_DOT) && (b1_q == CH_DOT);
	assign wp_m1    = wp_q - ONE;
	assign depth_m1 = depth_q - ONE;
	assign walk_more = (p_q != '0) && (rdata_q != CH_SLASH);
	assign p_fin    = ((p_q == '0) && (rdata_q == CH_SLASH)) ? ONE : p_q;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_READ) begin
						state_d = ST_RDATA;
					end else if (op == OP_END) begin
						state_d = (mode_q != MODE_START && cl_q != '0 && !is_dot && is_up &&
							(mode_q == MODE_ABS_DEEP || mode_q == MODE_REL_DEEP)) ?
							ST_WALK : ST_END;
					end else if (op == OP_BYTE && !ovf_q && mode_q != MODE_START &&
						path_byte == CH_SLASH && cl_q != '0 && is_up &&
						(mode_q == MODE_ABS_DEEP || mode_q == MODE_REL_DEEP)) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (!walk_more) begin
					state_d = pend_q ? ST_END : ST_IDLE;
				end
			end
			ST_END, ST_RDATA: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath: parsing, component commit, backward walk and result loading.
	always_comb begin
		mode_d  = mode_q;
		wp_d    = wp_q;
		cl_d    = cl_q;
		depth_d = depth_q;
		ovf_d   = ovf_q;
		pend_d  = pend_q;
		fill_d  = fill_q;
		p_d     = p_q;
		b0_d    = b0_q;
		b1_d    = b1_q;
		rdok_d  = rdok_q;
		ov_d    = ov_q && !out_ready;
		kind_d  = kind_q;
		obyte_d = obyte_q;
		olen_d  = olen_q;
		oflag_d = oflag_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = CH_SLASH;
		re      = 1'b0;
		raddr   = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_READ) begin
					re     = 1'b1;
					raddr  = AW'(read_index);
					rdok_d = (CW'(read_index) < CW'(wp_q)) &&
						(CW'(read_index) < CW'(MAXP));
				end else if (accept && op == OP_BYTE && !ovf_q && mode_q == MODE_START) begin
					depth_d = '0;
					we      = 1'b1;
					waddr   = '0;
					wdata   = path_byte;
					if (path_byte == CH_SLASH) begin
						wp_d   = ONE;
						cl_d   = '0;
						mode_d = MODE_ABS_ROOT;
					end else begin
						wp_d   = '0;
						cl_d   = ONE;
						b0_d   = path_byte;
						mode_d = MODE_REL_INIT;
					end
				end else if (accept && op == OP_BYTE && !ovf_q && path_byte != CH_SLASH) begin
					// Ordinary name byte.
					if (pos_cur >= MAXP) begin
						ovf_d = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = pos_cur[AW-1:0];
						wdata = path_byte;
						cl_d  = cl_q + ONE;
						if (cl_q == '0) begin
							b0_d = path_byte;
						end
						if (cl_q == ONE) begin
							b1_d = path_byte;
						end
					end
				end else if (accept && ((op == OP_BYTE && !ovf_q) ||
					(op == OP_END && mode_q != MODE_START))) begin
					// Finish the current component.
					pend_d = (op == OP_END);
					fill_d = 1'b1;
					if (cl_q != '0 && !is_dot) begin
						if (is_up && (mode_q == MODE_ABS_DEEP || mode_q == MODE_REL_DEEP)) begin
							// Start the backward walk at the last committed byte.
							p_d   = (wp_m1 >= MAXP) ? (MAXP - ONE) : wp_m1;
							re    = 1'b1;
							raddr = AW'((wp_m1 >= MAXP) ? (MAXP - ONE) : wp_m1);
						end else if (!(is_up && mode_q == MODE_ABS_ROOT)) begin
							// Commit, with a separator where one is needed.
							if (sep_cur && wp_q < MAXP) begin
								we    = 1'b1;
								waddr = wp_q[AW-1:0];
								wdata = CH_SLASH;
							end
							wp_d = pos_cur;
							case (mode_q)
								MODE_ABS_ROOT: begin
									mode_d  = MODE_ABS_DEEP;
									depth_d = ONE;
								end
								MODE_ABS_DEEP, MODE_REL_DEEP: begin
									depth_d = depth_q + ONE;
								end
								MODE_REL_INIT: begin
									mode_d = is_up ? MODE_REL_UP : MODE_REL_DEEP;
									if (!is_up) begin
										depth_d = ONE;
									end
								end
								default: begin
									if (!is_up) begin
										mode_d  = MODE_REL_DEEP;
										depth_d = ONE;
									end
								end
							endcase
						end
					end
					cl_d = '0;
				end else if (accept && op == OP_END) begin
					// End of an empty path.
					wp_d   = '0;
					fill_d = 1'b0;
				end
			end
			ST_WALK: begin
				if (walk_more) begin
					p_d   = p_q - ONE;
					re    = 1'b1;
					raddr = AW'(p_q - ONE);
				end else begin
					wp_d    = p_fin;
					depth_d = depth_m1;
					cl_d    = '0;
					if (depth_m1 == '0) begin
						mode_d = (mode_q == MODE_ABS_DEEP) ? MODE_ABS_ROOT :
							((p_fin == '0) ? MODE_REL_INIT : MODE_REL_UP);
					end
				end
			end
			ST_END: begin
				if (out_free) begin
					if (fill_q && wp_q == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = CH_DOT;
						wp_d  = ONE;
					end
					ov_d    = 1'b1;
					kind_d  = KIND_END;
					obyte_d = '0;
					olen_d  = 11'((fill_q && wp_q == '0) ? ONE : wp_q);
					oflag_d = ovf_q;
					mode_d  = MODE_START;
					cl_d    = '0;
					depth_d = '0;
					ovf_d   = 1'b0;
					pend_d  = 1'b0;
				end
			end
			ST_RDATA: begin
				if (out_free) begin
					ov_d    = 1'b1;
					kind_d  = KIND_READ;
					obyte_d = rdok_q ? rdata_q : '0;
					olen_d  = '0;
					oflag_d = 1'b0;
				end
			end
			default: begin
				ov_d = ov_q;
			end
		endcase
	end

	// Output register.
	assign out_valid   = ov_q;
	assign result_kind = kind_q;
	assign out_byte    = obyte_q;
	assign out_length  = olen_q;
	assign overflowed  = oflag_q;

`ifndef SYNTH
	// The committed length never passes the store capacity.
	assert property (@(posedge clk) disable iff (!arst_n) wp_q <= MAXP)
		else $error("write position beyond capacity");

	// The walk pointer stays below the committed length.
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_WALK |-> p_q < wp_q)
		else $error("walk pointer outside committed result");

	// Between paths no component or depth is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_START |-> (cl_q == '0 && depth_q == '0))
		else $error("stale component state at start of path");
`endif

endmodule

### tb/sv/path_canonicalizer_test.sv
// Self-checking testbench for the path canonicalizer: directed table, an overflow path, then random paths.
// Predicts every result with a behavioral model of the canonicalizer.
// Depends on pcanon_pkg and path_canonicalizer.
module path_canonicalizer_test;
	import pcanon_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 1024;
	localparam int ITEM_TARGET = 1850;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  path_byte;
	logic [9:0]  read_index;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [7:0]  out_byte;
	logic [10:0] out_length;
	logic        overflowed;

	path_canonicalizer #(.MAX_PATH_BYTES(CAPACITY)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .path_byte(path_byte), .read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
		.out_byte(out_byte), .out_length(out_length), .overflowed(overflowed)
	);

	typedef struct packed {
		logic        kind;
		logic [7:0]  rbyte;
		logic [10:0] len;
		logic        ovf;
	} canon_result_t;

	typedef struct {
		logic [1:0]    op;
		logic [7:0]    pbyte;
		logic [9:0]    idx;
		bit            typed;
		canon_result_t want;
	} stim_row_t;

	// Predictor state.
	logic [7:0] path_store [CAPACITY];
	int unsigned committed_len, seg_start, seg_len, depth;
	mode_t parse_st;
	bit ovf_seen;

	canon_result_t pending_results [$];
	int mismatches = 0;
	int results_seen = 0;
	int paths_done = 0;
	int overflow_paths = 0;
	int items_sent = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit slash_before();
		return parse_st == MODE_ABS_DEEP || parse_st == MODE_REL_DEEP ||
			parse_st == MODE_REL_UP;
	endfunction

	function automatic void append_segment();
		if (slash_before() && committed_len < CAPACITY)
			path_store[committed_len] = CH_SLASH;
		committed_len = seg_start + seg_len;
	endfunction

	// Back up to the previous separator, keeping a root slash.
	function automatic void remove_segment();
		int unsigned p;
		if (committed_len == 0)
			return;
		p = committed_len - 1;
		if (p >= CAPACITY)
			p = CAPACITY - 1;
		while (p > 0 && path_store[p] != CH_SLASH)
			p--;
		if (p == 0 && path_store[0] == CH_SLASH)
			p = 1;
		committed_len = p;
	endfunction

	function automatic void close_segment();
		bit single_dot, parent;
		if (seg_len == 0)
			return;
		single_dot = seg_len == 1 && path_store[seg_start] == CH_DOT;
		parent = seg_len == 2 && path_store[seg_start] == CH_DOT &&
			path_store[seg_start + 1] == CH_DOT;
		if (!single_dot) begin
			case (parse_st)
				MODE_ABS_ROOT: begin
					if (!parent) begin
						append_segment();
						parse_st = MODE_ABS_DEEP;
						depth = 1;
					end
				end
				MODE_ABS_DEEP: begin
					if (parent) begin
						remove_segment();
						depth--;
						if (depth == 0)
							parse_st = MODE_ABS_ROOT;
					end else begin
						append_segment();
						depth++;
					end
				end
				MODE_REL_INIT: begin
					append_segment();
					if (parent) begin
						parse_st = MODE_REL_UP;
					end else begin
						parse_st = MODE_REL_DEEP;
						depth = 1;
					end
				end
				MODE_REL_DEEP: begin
					if (parent) begin
						remove_segment();
						depth--;
						if (depth == 0)
							parse_st = (committed_len == 0) ? MODE_REL_INIT : MODE_REL_UP;
					end else begin
						append_segment();
						depth++;
					end
				end
				default: begin
					append_segment();
					if (!parent) begin
						parse_st = MODE_REL_DEEP;
						depth = 1;
					end
				end
			endcase
		end
		seg_len = 0;
		seg_start = committed_len + (slash_before() ? 1 : 0);
	endfunction

	// Advance the predictor by one transaction; returns 1 when a result is due.
	function automatic bit canon_predict(input logic [1:0] o, input logic [7:0] b,
			input logic [9:0] idx, output canon_result_t r);
		int unsigned pos;
		r = '0;
		if (o == OP_BYTE) begin
			if (ovf_seen)
				return 0;
			if (parse_st == MODE_START) begin
				committed_len = 0;
				seg_len = 0;
				depth = 0;
				if (b == CH_SLASH) begin
					path_store[0] = CH_SLASH;
					committed_len = 1;
					seg_start = 1;
					parse_st = MODE_ABS_ROOT;
					return 0;
				end
				seg_start = 0;
				parse_st = MODE_REL_INIT;
			end
			if (b == CH_SLASH) begin
				close_segment();
				return 0;
			end
			pos = seg_start + seg_len;
			if (pos >= CAPACITY) begin
				ovf_seen = 1'b1;
				return 0;
			end
			path_store[pos] = b;
			seg_len++;
			return 0;
		end
		if (o == OP_END) begin
			if (parse_st != MODE_START) begin
				close_segment();
				if (committed_len == 0) begin
					path_store[0] = CH_DOT;
					committed_len = 1;
				end
			end else begin
				committed_len = 0;
			end
			r.kind = KIND_END;
			r.len = committed_len[10:0];
			r.ovf = ovf_seen;
			paths_done++;
			if (ovf_seen)
				overflow_paths++;
			parse_st = MODE_START;
			seg_start = 0;
			seg_len = 0;
			depth = 0;
			ovf_seen = 1'b0;
			return 1;
		end
		if (o == OP_READ) begin
			r.kind = KIND_READ;
			r.rbyte = (idx < committed_len) ? path_store[idx] : 8'd0;
			return 1;
		end
		return 0;
	endfunction

	// Output side: random stall pattern and result checking.
	initial begin
		int stall_len;
		canon_result_t got, want;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			out_ready <= (stall_len == 0);
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{result_kind, out_byte, out_length, overflowed};
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind=%0d byte=%0h len=%0d ovf=%0d",
							got.kind, got.rbyte, got.len, got.ovf);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want kind=%0d byte=%0h len=%0d ovf=%0d, got kind=%0d byte=%0h len=%0d ovf=%0d",
								want.kind, want.rbyte, want.len, want.ovf,
								got.kind, got.rbyte, got.len, got.ovf);
					end
				end
			end
			while (stall_len > 1) begin
				stall_len--;
				@(posedge clk);
			end
		end
	end

	int gap_left = 0;

	// Present one transaction and wait until it is accepted; bursts with random gaps.
	// Valid stays high after acceptance until the next call or an explicit pause.
	task automatic send_transaction(input logic [1:0] o, input logic [7:0] b,
			input logic [9:0] idx);
		canon_result_t r;
		if (gap_left == 0 && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		path_byte <= b;
		read_index <= idx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (canon_predict(o, b, idx, r))
			pending_results.push_back(r);
		gap_left = (gap_left > 0) ? gap_left - 1 : $urandom_range(0, 20);
	endtask

	task automatic send_string(input string s);
		foreach (s[k])
			send_transaction(OP_BYTE, s[k], 10'($urandom));
	endtask

	// Finish a path; read back its first eight bytes, a random part of the rest and one past the end.
	task automatic end_and_read();
		send_transaction(OP_END, 8'($urandom), 10'($urandom));
		for (int unsigned k = 0; k <= committed_len && k < CAPACITY; k++)
			if (k < 8 || $urandom_range(0, 3) == 0 || k == committed_len)
				send_transaction(OP_READ, 8'($urandom), k[9:0]);
	endtask

	function automatic string random_segment();
		string s;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) return ".";
		if (pick < 5) return "..";
		if (pick == 5) return "";
		s = "";
		repeat ($urandom_range(1, 4)) begin
			logic [7:0] c;
			c = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(97, 122));
			if (c == CH_SLASH) c = 8'h00;
			s = {s, string'(c)};
		end
		return s;
	endfunction

	stim_row_t directed_rows [$];

	function automatic void add_row(logic [1:0] o, logic [7:0] b, logic [9:0] idx,
			bit typed = 0, canon_result_t want = '0);
		directed_rows.push_back('{o, b, idx, typed, want});
	endfunction

	// Directed rows: empty input, extremes, each special case; typed rows also check the
	// predictor against the expected result given in the table.
	initial begin
		add_row(OP_END, 8'hFF, 10'h3FF, 1, '{KIND_END, 8'd0, 11'd0, 1'b0});
		add_row(OP_NONE, 8'hAA, 10'h155);
		add_row(OP_BYTE, CH_SLASH, 10'd0);
		add_row(OP_END, 8'd0, 10'd0, 1, '{KIND_END, 8'd0, 11'd1, 1'b0});
		add_row(OP_READ, 8'd0, 10'd0, 1, '{KIND_READ, CH_SLASH, 11'd0, 1'b0});
		add_row(OP_READ, 8'd0, 10'h3FF, 1, '{KIND_READ, 8'd0, 11'd0, 1'b0});
		add_row(OP_BYTE, CH_SLASH, 10'd0);
		add_row(OP_BYTE, CH_DOT, 10'd0);
		add_row(OP_BYTE, CH_DOT, 10'd0);
		add_row(OP_BYTE, CH_SLASH, 10'd0);
		add_row(OP_BYTE, 8'hFF, 10'd0);
		add_row(OP_BYTE, 8'h00, 10'd0);
		add_row(OP_BYTE, CH_SLASH, 10'd0);
		add_row(OP_BYTE, CH_SLASH, 10'd0);
		add_row(OP_END, 8'd0, 10'd0, 1, '{KIND_END, 8'd0, 11'd3, 1'b0});
		add_row(OP_READ, 8'd0, 10'd1);
		add_row(OP_READ, 8'd0, 10'd2);
		add_row(OP_BYTE, CH_DOT, 10'd0);
		add_row(OP_END, 8'd0, 10'd0, 1, '{KIND_END, 8'd0, 11'd1, 1'b0});
		add_row(OP_READ, 8'd0, 10'd0, 1, '{KIND_READ, CH_DOT, 11'd0, 1'b0});
		add_row(OP_BYTE, CH_DOT, 10'd0);
		add_row(OP_BYTE, CH_DOT, 10'd0);
		add_row(OP_END, 8'd0, 10'd0, 1, '{KIND_END, 8'd0, 11'd2, 1'b0});
		add_row(OP_READ, 8'd0, 10'd1, 1, '{KIND_READ, CH_DOT, 11'd0, 1'b0});
	end

	initial begin
		in_valid <= 1'b0;
		op <= OP_BYTE;
		path_byte <= 8'd0;
		read_index <= 10'd0;
		arst_n <= 1'b0;
		committed_len = 0; seg_start = 0; seg_len = 0; depth = 0;
		parse_st = MODE_START;
		ovf_seen = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			send_transaction(directed_rows[n].op, directed_rows[n].pbyte, directed_rows[n].idx);
			if (directed_rows[n].typed && pending_results.size() > 0 &&
					pending_results[$] !== directed_rows[n].want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: predictor disagrees with table", n);
			end
		end

		// Overflow: one component longer than the store, read back at both ends and in the middle.
		repeat (CAPACITY + 3) send_transaction(OP_BYTE, 8'h61, 10'd0);
		send_transaction(OP_END, 8'd0, 10'd0);
		send_transaction(OP_READ, 8'd0, 10'd0);
		send_transaction(OP_READ, 8'd0, 10'd512);
		send_transaction(OP_READ, 8'd0, 10'(CAPACITY - 1));

		// Hold off until every result is back.
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		// Random paths: mostly well-formed, some noise.
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(0, 6))
					send_transaction(2'($urandom), 8'($urandom), 10'($urandom));
			end else begin
				if ($urandom_range(0, 1)) send_string("/");
				repeat ($urandom_range(0, 6)) begin
					send_string(random_segment());
					repeat ($urandom_range(1, 2)) send_string("/");
				end
				if ($urandom_range(0, 1)) send_string(random_segment());
			end
			end_and_read();
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d transactions and checked %0d results over %0d paths,",
			items_sent, results_seen, paths_done);
		$display("%0d of those paths overflowing the store.", overflow_paths);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[path_canonicalizer] OK");
		else
			$display("[path_canonicalizer] ERROR");
		$finish;
	end

	initial begin
		#30ms;
		$display("[path_canonicalizer] ERROR");
		$finish;
	end
endmodule

### filelist.f
design/pcanon_pkg.sv
design/path_canonicalizer.sv
tb/sv/path_canonicalizer_test.sv
